FILE: rtl/uart_la_pkg.sv
package uart_la_pkg;

   // request codes
   localparam logic [1:0] REQ_CHAR    = 2'd0;
   localparam logic [1:0] REQ_READ    = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   // characters that steer the line parser
   localparam logic [6:0] CH_PROMPT = 7'd62;
   localparam logic [6:0] CH_CR     = 7'd13;
   localparam logic [6:0] CH_LF     = 7'd10;
   localparam logic [6:0] CH_SPACE  = 7'd32;

   typedef struct packed {
      logic [1:0] req_type;
      logic [8:0] char_code;
      logic [8:0] byte_offset;
   } req_payload_type;

   typedef struct packed {
      logic       line_done;
      logic       error_flag;
      logic [6:0] read_byte;
      logic       head_ready;
      logic [8:0] head_length;
   } rsp_payload_type;

endpackage

FILE: rtl/uart_la_if.sv
interface uart_la_req_if;
   import uart_la_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface uart_la_rsp_if;
   import uart_la_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/uart_line_assembler.sv
// Gathers received UART characters into a ring of SLOTS line slots of LINE_BYTES-1
// 7-bit characters each, and serves the consumer from the oldest completed line.
// Each request on req_if is a received character, a read of one byte of the head
// line, or a release of the head line; every request gives exactly one response on
// rsp_if. Zero and codes of 128 or more are dropped. A line ends at CR LF (LF not
// stored, a trailing CR trimmed) or at a leading "> " prompt; bytes past LINE_BYTES-1
// are dropped. If a line starts while the next slot is still full, error_flag rises
// and every character is dropped until a release. Rate: one request per clock,
// sustained while rsp_if.ready holds; the registered response appears in the cycle
// after acceptance, read data from the registered read port of the single line store
// memory (SLOTS*LINE_BYTES entries, at most one write or read per request). A stalled
// response is held in the output register while the next request is still taken in
// the same cycle it is popped. The line store needs no clearing after reset: a byte
// is read only below a completed line's length, and every such byte was written.
module uart_line_assembler #(
   parameter int SLOTS      = 4,
   parameter int LINE_BYTES = 512
) (
   input  logic           clock,
   input  logic           reset,
   uart_la_req_if.sink    req_if,
   uart_la_rsp_if.source  rsp_if
);
   import uart_la_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LEN_W  = $clog2(LINE_BYTES);
   localparam int ADDR_W = $clog2(SLOTS * LINE_BYTES);
   localparam int CMP_W  = (LEN_W > 9) ? LEN_W : 9;
   localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(LINE_BYTES - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

   // parser modes
   localparam logic [2:0] MODE_IDLE       = 3'd0;
   localparam logic [2:0] MODE_LINE       = 3'd1;
   localparam logic [2:0] MODE_WAIT_LF    = 3'd2;
   localparam logic [2:0] MODE_WAIT_SPACE = 3'd3;
   localparam logic [2:0] MODE_ERROR      = 3'd4;

   // parser and ring state
   logic [2:0]        mode_ff, mode_in;
   logic [SLOT_W-1:0] wslot_ff, wslot_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   logic [SLOTS-1:0]  ready_ff, ready_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;   // length of the line being built
   logic              last_cr_ff, last_cr_in;   // last stored byte of that line is CR
   logic [LEN_W-1:0]  slot_len_ff [SLOTS];      // lengths of completed lines

   // line store
   logic [6:0]        store_mem [SLOTS * LINE_BYTES];
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              mem_we, mem_re;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              done_ff, done_in;
   logic              error_ff;
   logic              hit_ff, hit_in;
   logic              hready_ff, hready_in;
   logic [8:0]        hlen_ff, hlen_in;
   logic [6:0]        rd_data_ff;

   logic              accept;
   logic              char_ok;
   logic              store;
   logic              do_store;
   logic              finish;
   logic [6:0]        ch;
   logic [LEN_W-1:0]  len_eff;
   logic              cr_eff;
   logic [LEN_W-1:0]  final_len;
   logic              head_full;

   // Take a new request whenever the output register is empty or being drained.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign ch      = req_if.payload.char_code[6:0];
   assign char_ok = (req_if.payload.char_code[8:7] == 2'b00) && (ch != 7'd0);
   assign head_full = ready_ff[rslot_ff];

   // Decide the parser step for a received character.
   always_comb begin
      mode_in = mode_ff;
      store   = 1'b0;
      finish  = 1'b0;
      if (accept && req_if.payload.req_type == REQ_CHAR && char_ok) begin
         case (mode_ff)
            MODE_IDLE: begin
               if (ready_ff[wslot_ff]) begin
                  // ring is full: drop and wait for a release
                  mode_in = MODE_ERROR;
               end else begin
                  store = 1'b1;
                  if (ch == CH_PROMPT) begin
                     mode_in = MODE_WAIT_SPACE;
                  end else if (ch == CH_CR) begin
                     mode_in = MODE_WAIT_LF;
                  end else begin
                     mode_in = MODE_LINE;
                  end
               end
            end
            MODE_LINE: begin
               store = 1'b1;
               if (ch == CH_CR) begin
                  mode_in = MODE_WAIT_LF;
               end
            end
            MODE_WAIT_LF: begin
               if (ch == CH_LF) begin
                  finish = 1'b1;
               end else begin
                  store   = 1'b1;
                  mode_in = MODE_LINE;
               end
            end
            MODE_WAIT_SPACE: begin
               store = 1'b1;
               if (ch == CH_SPACE) begin
                  finish = 1'b1;
               end else if (ch == CH_CR) begin
                  mode_in = MODE_WAIT_LF;
               end else begin
                  mode_in = MODE_LINE;
               end
            end
            MODE_ERROR: begin
               mode_in = MODE_ERROR;
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
         if (finish) begin
            mode_in = MODE_IDLE;
         end
      end else if (accept && req_if.payload.req_type == REQ_RELEASE && head_full
                   && mode_ff == MODE_ERROR) begin
         // a freed slot clears the overflow
         mode_in = MODE_IDLE;
      end
   end

   // Store the byte only while the slot has room; trim a trailing CR at the end.
   assign do_store  = store && (cur_len_ff < LEN_MAX);
   assign len_eff   = do_store ? cur_len_ff + LEN_W'(1) : cur_len_ff;
   assign cr_eff    = do_store ? (ch == CH_CR) : last_cr_ff;
   assign final_len = cr_eff ? len_eff - LEN_W'(1) : len_eff;

   always_comb begin
      wslot_in   = wslot_ff;
      rslot_in   = rslot_ff;
      ready_in   = ready_ff;
      cur_len_in = len_eff;
      last_cr_in = cr_eff;
      hready_in  = 1'b0;
      hlen_in    = 9'd0;
      if (finish) begin
         ready_in[wslot_ff] = 1'b1;
         wslot_in   = (wslot_ff == SLOT_LAST) ? '0 : wslot_ff + SLOT_W'(1);
         cur_len_in = '0;
         last_cr_in = 1'b0;
      end
      if (accept && req_if.payload.req_type == REQ_RELEASE && head_full) begin
         hready_in          = 1'b1;
         hlen_in            = 9'(slot_len_ff[rslot_ff]);
         ready_in[rslot_ff] = 1'b0;
         rslot_in = (rslot_ff == SLOT_LAST) ? '0 : rslot_ff + SLOT_W'(1);
      end
   end

   // Memory addresses: slot base plus byte position.
   assign wr_addr = ADDR_W'(wslot_ff) * ADDR_W'(LINE_BYTES) + ADDR_W'(cur_len_ff);
   assign rd_addr = ADDR_W'(rslot_ff) * ADDR_W'(LINE_BYTES)
                  + ADDR_W'(LEN_W'(req_if.payload.byte_offset));
   assign mem_we  = do_store;
   assign mem_re  = accept && req_if.payload.req_type == REQ_READ;

   // A read hits only a completed head line below its length.
   assign hit_in  = mem_re && head_full
                  && (CMP_W'(req_if.payload.byte_offset) < CMP_W'(slot_len_ff[rslot_ff]));
   assign done_in = finish;

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_addr] <= ch;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         slot_len_ff[wslot_ff] <= final_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         wslot_ff   <= '0;
         rslot_ff   <= '0;
         ready_ff   <= '0;
         cur_len_ff <= '0;
         last_cr_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         wslot_ff   <= wslot_in;
         rslot_ff   <= rslot_in;
         ready_ff   <= ready_in;
         cur_len_ff <= cur_len_in;
         last_cr_ff <= last_cr_in;
      end
   end

   // Response register: load on accept, hold while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff   <= done_in;
         error_ff  <= (mode_in == MODE_ERROR);
         hit_ff    <= hit_in;
         hready_ff <= hready_in;
         hlen_ff   <= hlen_in;
      end
   end

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.payload.line_done   = done_ff;
   assign rsp_if.payload.error_flag  = error_ff;
   assign rsp_if.payload.read_byte   = hit_ff ? rd_data_ff : 7'd0;
   assign rsp_if.payload.head_ready  = hready_ff;
   assign rsp_if.payload.head_length = hlen_ff;

`ifndef ASSERT_OFF
   // Overflow is only ever entered or kept with the whole ring full.
   a_error_means_full: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ERROR |-> ready_ff[wslot_ff])
      else $error("parser in error mode while the write slot is free");

   // Between lines nothing is pending for the write slot.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> (cur_len_ff == '0 && !last_cr_ff))
      else $error("idle parser with a partial line pending");

   // The line being built never exceeds its slot.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      cur_len_ff <= LEN_MAX)
      else $error("line length beyond slot capacity");

   // A completed line always leaves the parser out of the error mode.
   a_done_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !error_ff)
      else $error("line completion reported together with overflow");
`endif

endmodule
